>>> rtl/rpbb_pkg.sv
// shared widths, register reset values and types of the rotated point bounding box
package rpbb_pkg;

	localparam int COORD_WIDTH    = 24;
	localparam int COEF_FRAC_BITS = 14;
	localparam int COEF_WIDTH     = 16;
	localparam int BOX_WIDTH      = 27;
	localparam int NUM_AXES       = 3;
	localparam int ROW_WIDTH      = NUM_AXES * COEF_WIDTH;
	localparam int PROD_WIDTH     = COORD_WIDTH + COEF_WIDTH;
	localparam int SUM_WIDTH      = PROD_WIDTH + 2;
	localparam int CFG_IDX_WIDTH  = 2;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_AXIS_ROW0 = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_AXIS_ROW1 = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_AXIS_ROW2 = 2'd2;

	localparam logic [ROW_WIDTH-1:0] AXIS_ROW0_RESET = ROW_WIDTH'(64'd16384);
	localparam logic [ROW_WIDTH-1:0] AXIS_ROW1_RESET = ROW_WIDTH'(64'd1073741824);
	localparam logic [ROW_WIDTH-1:0] AXIS_ROW2_RESET = ROW_WIDTH'(64'd70368744177664);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [COEF_WIDTH-1:0]  coef_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic signed [SUM_WIDTH-1:0]   sum_t;
	typedef logic signed [BOX_WIDTH-1:0]   box_t;
	typedef logic [ROW_WIDTH-1:0]          axis_row_t;

endpackage

>>> rtl/rotated_point_bounding_box_core.sv
// rotated point bounding box: vertex rotation by a 3x3 axis matrix and running min/max box
//
// input channel: in_valid/in_ready carry one vertex transaction per cycle while
// in_ready is high, with vertex_x/y/z (signed Q16.8), has_vertex and last. a
// transaction without has_vertex only marks the end of a model.
// output channel: out_valid/out_ready carry one box transaction (min/max of
// the rotated x, y, z, signed Q19.8) for each input transaction with last set.
// a model with no vertex gives an all-zero box; the box is cleared after each one.
// config port: cfg_write with cfg_index 0..2 loads axis_row0..2, taking effect
// at once; index 3 is ignored. write only while the block is idle.
// pipeline: input register, product register (nine 24x16 multipliers), then
// the sum, floor shift and min/max update into the box and result registers.
// the last transaction passes the input and product registers, then its box
// shows in the result register. throughput: one transaction per cycle when not stalled.
// a stalled receiver holds the result register; non-last transactions keep
// flowing, and a last transaction waits in the pipeline only while the
// result register is full, which then backs up into in_ready.
// reset: axis rows return to identity, box and pipeline are emptied.
module rotated_point_bounding_box_core
	import rpbb_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [ROW_WIDTH-1:0]     cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [COORD_WIDTH-1:0] vertex_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_y,
	input  logic signed [COORD_WIDTH-1:0] vertex_z,
	input  logic                     has_vertex,
	input  logic                     last,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [BOX_WIDTH-1:0] min_x,
	output logic signed [BOX_WIDTH-1:0] min_y,
	output logic signed [BOX_WIDTH-1:0] min_z,
	output logic signed [BOX_WIDTH-1:0] max_x,
	output logic signed [BOX_WIDTH-1:0] max_y,
	output logic signed [BOX_WIDTH-1:0] max_z
);

	axis_row_t axis_row_q [NUM_AXES];

	logic   valid_s1, has_s1, last_s1;
	coord_t coord_s1 [NUM_AXES];

	logic  valid_s2, has_s2, last_s2;
	prod_t prod_s2 [NUM_AXES][NUM_AXES];

	box_t box_min_q [NUM_AXES];
	box_t box_max_q [NUM_AXES];
	logic seen_q;

	logic out_valid_q;
	box_t out_min_q [NUM_AXES];
	box_t out_max_q [NUM_AXES];

	logic  adv_s2, en_s2;
	prod_t prod_d [NUM_AXES][NUM_AXES];
	box_t  rot [NUM_AXES];
	box_t  min_next [NUM_AXES];
	box_t  max_next [NUM_AXES];
	sum_t  sum [NUM_AXES];

	assign adv_s2   = valid_s2 && (!last_s2 || !out_valid_q || out_ready);
	assign en_s2    = !valid_s2 || adv_s2;
	assign in_ready = !valid_s1 || en_s2;

	// product of coordinate r with coefficient c of row r
	always_comb begin
		for (int c = 0; c < NUM_AXES; c++) begin
			for (int r = 0; r < NUM_AXES; r++) begin
				prod_d[c][r] = PROD_WIDTH'(coord_s1[r] *
					coef_t'(axis_row_q[r][c*COEF_WIDTH +: COEF_WIDTH]));
			end
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_AXES; c++) begin
			sum[c] = SUM_WIDTH'(prod_s2[c][0]) + SUM_WIDTH'(prod_s2[c][1])
				+ SUM_WIDTH'(prod_s2[c][2]);
			rot[c] = BOX_WIDTH'(sum[c] >>> COEF_FRAC_BITS);
			min_next[c] = box_min_q[c];
			max_next[c] = box_max_q[c];
			if (has_s2) begin
				if (!seen_q) begin
					min_next[c] = rot[c];
					max_next[c] = rot[c];
				end else begin
					if (rot[c] < box_min_q[c]) min_next[c] = rot[c];
					if (rot[c] > box_max_q[c]) max_next[c] = rot[c];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_row_q[0] <= AXIS_ROW0_RESET;
			axis_row_q[1] <= AXIS_ROW1_RESET;
			axis_row_q[2] <= AXIS_ROW2_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_AXIS_ROW0: axis_row_q[0] <= cfg_data;
				REG_AXIS_ROW1: axis_row_q[1] <= cfg_data;
				REG_AXIS_ROW2: axis_row_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			coord_s1[0] <= vertex_x;
			coord_s1[1] <= vertex_y;
			coord_s1[2] <= vertex_z;
			has_s1      <= has_vertex;
			last_s1     <= last;
		end
	end

	// product register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			prod_s2 <= prod_d;
			has_s2  <= has_s1;
			last_s2 <= last_s1;
		end
	end

	// running box
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			for (int c = 0; c < NUM_AXES; c++) begin
				box_min_q[c] <= '0;
				box_max_q[c] <= '0;
			end
		end else if (adv_s2) begin
			if (last_s2) begin
				seen_q <= 1'b0;
				for (int c = 0; c < NUM_AXES; c++) begin
					box_min_q[c] <= '0;
					box_max_q[c] <= '0;
				end
			end else begin
				seen_q    <= seen_q || has_s2;
				box_min_q <= min_next;
				box_max_q <= max_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2 && last_s2) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && last_s2) begin
			out_min_q <= min_next;
			out_max_q <= max_next;
		end
	end

	assign out_valid = out_valid_q;
	assign min_x     = out_min_q[0];
	assign min_y     = out_min_q[1];
	assign min_z     = out_min_q[2];
	assign max_x     = out_max_q[0];
	assign max_y     = out_max_q[1];
	assign max_z     = out_max_q[2];

endmodule
